### design/mwc_pkg.sv
// Shared types and codes for the motion wake controller.
// No dependencies; used by the decision logic and the top level.
package mwc_pkg;

   // Opcode of a request
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_UPLOAD = 1'b1;

   // Controller modes
   localparam logic [1:0] MODE_QUICK  = 2'd0;
   localparam logic [1:0] MODE_ACTIVE = 2'd1;
   localparam logic [1:0] MODE_UPLOAD = 2'd2;

   // Actions returned with every response
   localparam logic [2:0] ACT_CONTINUE     = 3'd0;
   localparam logic [2:0] ACT_RETRY        = 3'd1;
   localparam logic [2:0] ACT_SLEEP_NORMAL = 3'd2;
   localparam logic [2:0] ACT_SLEEP_LONG   = 3'd3;
   localparam logic [2:0] ACT_UPLOAD       = 3'd4;

   // CSR indexes
   localparam logic [2:0] CSR_MOTION_THR   = 3'd0;
   localparam logic [2:0] CSR_STABLE_THR   = 3'd1;
   localparam logic [2:0] CSR_CONFIRM_TIME = 3'd2;
   localparam logic [2:0] CSR_BASE_INTVL   = 3'd3;
   localparam logic [2:0] CSR_QUIET_PERIOD = 3'd4;
   localparam logic [2:0] CSR_WINDOW       = 3'd5;
   localparam logic [2:0] CSR_UPLOAD_GAP   = 3'd6;

   // Usable distance range, sixteenths of a centimeter
   localparam logic [15:0] DIST_MIN = 16'd32;
   localparam logic [15:0] DIST_MAX = 16'd6400;

   typedef struct packed {
      logic [12:0] motion_threshold;
      logic [12:0] stable_threshold;
      logic [31:0] confirm_time_ms;
      logic [31:0] baseline_interval_ms;
      logic [31:0] quiet_period_ms;
      logic [31:0] window_ms;
      logic [31:0] min_upload_gap_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      motion_threshold:     13'd160,
      stable_threshold:     13'd80,
      confirm_time_ms:      32'd2000,
      baseline_interval_ms: 32'd300000,
      quiet_period_ms:      32'd300000,
      window_ms:            32'd30000,
      min_upload_gap_ms:    32'd60000
   };

   typedef struct packed {
      logic        op;
      logic        sample_valid;
      logic [15:0] distance;
      logic [31:0] now_ms;
      logic        upload_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [1:0]  mode;
      logic        motion_now;
      logic        motion_confirmed;
      logic [12:0] baseline_out;
      logic [31:0] motion_events;
      logic [31:0] upload_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [12:0] baseline;
      logic        baseline_set;
      logic [31:0] baseline_time;
      logic [31:0] last_motion_time;
      logic [31:0] last_upload_time;
      logic [31:0] motion_event_total;
      logic [31:0] upload_total;
      logic        motion_active;
      logic [31:0] window_start;
      logic [12:0] prev_distance;
      logic        prev_valid;
      logic [31:0] stable_start;
      logic        stable_armed;
      logic        confirmed;
   } state_type;

endpackage

### design/mwc_req_if.sv
// Request channel of the motion wake controller: valid/ready plus sample payload.
// Standalone; field widths follow the mwc_pkg request type.
interface mwc_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic        sample_valid;
   logic [15:0] distance;
   logic [31:0] now_ms;
   logic        upload_ok;

   modport source (output valid, output op, output sample_valid, output distance,
                   output now_ms, output upload_ok, input ready);
   modport sink   (input valid, input op, input sample_valid, input distance,
                   input now_ms, input upload_ok, output ready);
endinterface

### design/mwc_rsp_if.sv
// Response channel of the motion wake controller: valid/ready plus decision payload.
// Standalone; field widths follow the mwc_pkg response type.
interface mwc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [1:0]  mode;
   logic        motion_now;
   logic        motion_confirmed;
   logic [12:0] baseline_out;
   logic [31:0] motion_events;
   logic [31:0] upload_count;

   modport source (output valid, output action, output mode, output motion_now,
                   output motion_confirmed, output baseline_out, output motion_events,
                   output upload_count, input ready);
   modport sink   (input valid, input action, input mode, input motion_now,
                   input motion_confirmed, input baseline_out, input motion_events,
                   input upload_count, output ready);
endinterface

### design/mwc_step.sv
// Decision logic for one request: next controller state and the response.
// Depends on mwc_pkg for the state, config, request and response types.
module mwc_step (
   input  mwc_pkg::state_type st,
   input  mwc_pkg::cfg_type   cfg,
   input  mwc_pkg::req_type   req,
   output mwc_pkg::state_type st_next,
   output mwc_pkg::rsp_type   rsp
);

   function automatic logic [12:0] abs_diff(input logic [12:0] a, input logic [12:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [12:0] sample_dist;
   logic        usable;
   logic        dev_motion;
   logic        stable_step;
   logic [31:0] since_window;
   logic [31:0] since_upload;
   logic [31:0] since_stable;
   logic [31:0] since_base;
   logic [31:0] since_motion;
   logic        refresh;
   logic [2:0]  action;
   logic        motion_now;

   assign sample_dist = req.distance[12:0];
   assign usable = req.sample_valid && (req.distance >= mwc_pkg::DIST_MIN) &&
                   (req.distance <= mwc_pkg::DIST_MAX);

   assign dev_motion  = st.baseline_set &&
                        (abs_diff(sample_dist, st.baseline) > cfg.motion_threshold);
   assign stable_step = st.prev_valid &&
                        (abs_diff(sample_dist, st.prev_distance) < cfg.stable_threshold);

   // time differences wrap modulo 2^32
   assign since_window = req.now_ms - st.window_start;
   assign since_upload = req.now_ms - st.last_upload_time;
   assign since_stable = req.now_ms - st.stable_start;
   assign since_base   = req.now_ms - st.baseline_time;
   assign since_motion = req.now_ms - st.last_motion_time;

   assign refresh = (since_base > cfg.baseline_interval_ms) && !st.motion_active;

   always_comb begin
      st_next    = st;
      action     = mwc_pkg::ACT_CONTINUE;
      motion_now = 1'b0;
      unique case (st.mode)
         mwc_pkg::MODE_UPLOAD: begin
            if (req.op == mwc_pkg::OP_UPLOAD) begin
               if (req.upload_ok) begin
                  st_next.upload_total     = st.upload_total + 32'd1;
                  st_next.last_upload_time = req.now_ms;
               end
               st_next.motion_active = 1'b0;
               st_next.mode          = mwc_pkg::MODE_QUICK;
               action                = mwc_pkg::ACT_SLEEP_NORMAL;
            end
         end
         mwc_pkg::MODE_ACTIVE: begin
            if (req.op == mwc_pkg::OP_SAMPLE) begin
               if (since_window >= cfg.window_ms) begin
                  // window over: the sample itself is not evaluated
                  if (st.confirmed && (since_upload >= cfg.min_upload_gap_ms)) begin
                     st_next.mode = mwc_pkg::MODE_UPLOAD;
                     action       = mwc_pkg::ACT_UPLOAD;
                  end else begin
                     st_next.motion_active = 1'b0;
                     st_next.mode          = mwc_pkg::MODE_QUICK;
                     action                = mwc_pkg::ACT_SLEEP_NORMAL;
                  end
               end else if (usable) begin
                  motion_now = dev_motion;
                  if (dev_motion && stable_step) begin
                     if (!st.stable_armed) begin
                        st_next.stable_armed = 1'b1;
                        st_next.stable_start = req.now_ms;
                     end else if (since_stable >= cfg.confirm_time_ms) begin
                        st_next.confirmed = 1'b1;
                     end
                  end else begin
                     st_next.stable_armed = 1'b0;
                  end
                  st_next.prev_distance = sample_dist;
                  st_next.prev_valid    = 1'b1;
               end
            end
         end
         default: begin
            st_next.mode = mwc_pkg::MODE_QUICK;
            if (req.op == mwc_pkg::OP_SAMPLE) begin
               if (!usable) begin
                  action = mwc_pkg::ACT_RETRY;
               end else if (!st.baseline_set) begin
                  st_next.baseline      = sample_dist;
                  st_next.baseline_set  = 1'b1;
                  st_next.baseline_time = req.now_ms;
                  action                = mwc_pkg::ACT_RETRY;
               end else begin
                  if (refresh) begin
                     st_next.baseline      = sample_dist;
                     st_next.baseline_time = req.now_ms;
                  end
                  // a refreshed baseline equals the sample, so it never shows motion
                  motion_now = dev_motion && !refresh;
                  if (motion_now) begin
                     st_next.motion_active      = 1'b1;
                     st_next.last_motion_time   = req.now_ms;
                     st_next.motion_event_total = st.motion_event_total + 32'd1;
                     st_next.window_start       = req.now_ms;
                     st_next.prev_valid         = 1'b0;
                     st_next.stable_armed       = 1'b0;
                     st_next.confirmed          = 1'b0;
                     st_next.mode               = mwc_pkg::MODE_ACTIVE;
                     action                     = mwc_pkg::ACT_CONTINUE;
                  end else if ((st.last_motion_time != 32'd0) &&
                               (since_motion > cfg.quiet_period_ms)) begin
                     action = mwc_pkg::ACT_SLEEP_LONG;
                  end else begin
                     action = mwc_pkg::ACT_SLEEP_NORMAL;
                  end
               end
            end
         end
      endcase
   end

   always_comb begin
      rsp.action           = action;
      rsp.mode             = st_next.mode;
      rsp.motion_now       = motion_now;
      rsp.motion_confirmed = st_next.confirmed;
      rsp.baseline_out     = st_next.baseline_set ? st_next.baseline : 13'd0;
      rsp.motion_events    = st_next.motion_event_total;
      rsp.upload_count     = st_next.upload_total;
   end

endmodule

### design/motion_wake_controller.sv
// Motion wake controller: takes one request per cycle while rsp_chan is ready and
// returns one response per request via the request register, then the response
// register, with the decision logic between them. The request register lets a new
// request enter while an earlier response waits. CSR writes are plain, take effect
// on the next cycle and must only be issued while the block is idle.
// Depends on mwc_pkg, mwc_req_if, mwc_rsp_if and mwc_step.
module motion_wake_controller (
   input  logic          clock,
   input  logic          reset,
   mwc_req_if.sink       req_chan,
   mwc_rsp_if.source     rsp_chan,
   input  logic          csr_wr_en,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_wdata
);

   mwc_pkg::cfg_type   cfg_ff,  cfg_in;
   mwc_pkg::state_type st_ff,   st_in;
   mwc_pkg::req_type   req_data_ff;
   mwc_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic               req_valid_ff;
   logic               rsp_valid_ff;
   logic               advance;
   logic               take;

   // move the held request into the response register when it is free or draining
   assign advance = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign take    = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !req_valid_ff || advance;

   mwc_step u_step (
      .st      (st_ff),
      .cfg     (cfg_ff),
      .req     (req_data_ff),
      .st_next (st_in),
      .rsp     (rsp_data_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            mwc_pkg::CSR_MOTION_THR:   cfg_in.motion_threshold     = csr_wdata[12:0];
            mwc_pkg::CSR_STABLE_THR:   cfg_in.stable_threshold     = csr_wdata[12:0];
            mwc_pkg::CSR_CONFIRM_TIME: cfg_in.confirm_time_ms      = csr_wdata;
            mwc_pkg::CSR_BASE_INTVL:   cfg_in.baseline_interval_ms = csr_wdata;
            mwc_pkg::CSR_QUIET_PERIOD: cfg_in.quiet_period_ms      = csr_wdata;
            mwc_pkg::CSR_WINDOW:       cfg_in.window_ms            = csr_wdata;
            mwc_pkg::CSR_UPLOAD_GAP:   cfg_in.min_upload_gap_ms    = csr_wdata;
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= mwc_pkg::CFG_RESET;
         st_ff        <= '0;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (advance) begin
            st_ff <= st_in;
         end
         if (req_chan.ready) begin
            req_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_data_ff.op           <= req_chan.op;
         req_data_ff.sample_valid <= req_chan.sample_valid;
         req_data_ff.distance     <= req_chan.distance;
         req_data_ff.now_ms       <= req_chan.now_ms;
         req_data_ff.upload_ok    <= req_chan.upload_ok;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.action           = rsp_data_ff.action;
   assign rsp_chan.mode             = rsp_data_ff.mode;
   assign rsp_chan.motion_now       = rsp_data_ff.motion_now;
   assign rsp_chan.motion_confirmed = rsp_data_ff.motion_confirmed;
   assign rsp_chan.baseline_out     = rsp_data_ff.baseline_out;
   assign rsp_chan.motion_events    = rsp_data_ff.motion_events;
   assign rsp_chan.upload_count     = rsp_data_ff.upload_count;

endmodule
